/* design/sstd_pkg.sv */
// ----------------------------------------------------------------------------
// sstd_pkg
// Shared types and constants for the swing structure trend detector.
// ----------------------------------------------------------------------------
package sstd_pkg;

  localparam int MAX_STRENGTH = 16;
  localparam int PRICE_BITS   = 32;
  localparam int WIN_DEPTH    = 2 * MAX_STRENGTH + 1;
  localparam int WIN_IDX_W    = $clog2(WIN_DEPTH);
  localparam int STR_W        = 5;
  localparam int BARS_W       = 7;
  localparam int CONF_W       = 7;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [BARS_W-1:0] BARS_MAX  = 7'd127;
  localparam logic [1:0]        PAIR_FULL = 2'd2;

  localparam logic [STR_W-1:0] STRENGTH_RESET = 5'd2;
  localparam logic [STR_W-1:0] STRENGTH_MIN   = 5'd1;
  localparam logic [STR_W-1:0] STRENGTH_MAX   = 5'(MAX_STRENGTH);

  localparam logic [CONF_W-1:0] CONF_STRONG  = 7'd90;
  localparam logic [CONF_W-1:0] CONF_PLAIN   = 7'd70;
  localparam logic [CONF_W-1:0] CONF_RANGING = 7'd40;

  localparam logic signed [1:0] SIG_LONG  = 2'sd1;
  localparam logic signed [1:0] SIG_NONE  = 2'sd0;
  localparam logic signed [1:0] SIG_SHORT = -2'sd1;

  typedef enum logic [2:0] {
    TREND_STRONG_BULL = 3'd0,
    TREND_BULL        = 3'd1,
    TREND_RANGING     = 3'd2,
    TREND_BEAR        = 3'd3,
    TREND_STRONG_BEAR = 3'd4
  } trend_e;

  // classified bar handed from front to back
  typedef struct packed {
    logic                  clear;
    logic                  is_high;
    logic                  is_low;
    logic                  enough;
    logic [PRICE_BITS-1:0] centre_high;
    logic [PRICE_BITS-1:0] centre_low;
    logic [PRICE_BITS-1:0] close;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* design/sstd_front.sv */
// ----------------------------------------------------------------------------
// sstd_front
// Shifts each bar into the high and low windows and runs the swing test.
// ----------------------------------------------------------------------------
module sstd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           q_full_i,
  input  logic [sstd_pkg::STR_W-1:0]     strength_i,
  input  logic                           series_start_i,
  input  logic [sstd_pkg::PRICE_BITS-1:0] bar_high_i,
  input  logic [sstd_pkg::PRICE_BITS-1:0] bar_low_i,
  input  logic [sstd_pkg::PRICE_BITS-1:0] bar_close_i,
  output logic                           in_ready_o,
  output logic                           push_o,
  output sstd_pkg::rec_t                 rec_o
);

  logic [sstd_pkg::PRICE_BITS-1:0] high_win_q [sstd_pkg::WIN_DEPTH];
  logic [sstd_pkg::PRICE_BITS-1:0] low_win_q  [sstd_pkg::WIN_DEPTH];
  logic [sstd_pkg::PRICE_BITS-1:0] high_sh    [sstd_pkg::WIN_DEPTH];
  logic [sstd_pkg::PRICE_BITS-1:0] low_sh     [sstd_pkg::WIN_DEPTH];
  logic [sstd_pkg::BARS_W-1:0]     bars_q, bars_d, bars_base;
  logic [sstd_pkg::WIN_IDX_W-1:0]  centre_idx;
  logic [sstd_pkg::WIN_IDX_W-1:0]  span;
  logic [sstd_pkg::PRICE_BITS-1:0] centre_high, centre_low;
  logic                            test_en, is_high, is_low, enough;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // window after this bar, entry 0 newest
  always_comb begin
    high_sh[0] = bar_high_i;
    low_sh[0]  = bar_low_i;
    for (int k = 1; k < sstd_pkg::WIN_DEPTH; k++) begin
      high_sh[k] = high_win_q[k-1];
      low_sh[k]  = low_win_q[k-1];
    end
  end

  always_comb begin
    bars_base = series_start_i ? '0 : bars_q;
    bars_d    = (bars_base == sstd_pkg::BARS_MAX) ? bars_base
                                                   : bars_base + sstd_pkg::BARS_W'(1);
  end

  assign centre_idx  = {1'b0, strength_i};
  assign span        = {strength_i, 1'b0};
  assign centre_high = high_sh[centre_idx];
  assign centre_low  = low_sh[centre_idx];
  assign test_en     = bars_d >= ({1'b0, span} + sstd_pkg::BARS_W'(1));
  assign enough      = bars_d >= {strength_i, 2'b00};

  // all neighbor compares side by side
  always_comb begin
    is_high = test_en;
    is_low  = test_en;
    for (int k = 0; k < sstd_pkg::WIN_DEPTH; k++) begin
      if ((sstd_pkg::WIN_IDX_W'(k) != centre_idx) && (sstd_pkg::WIN_IDX_W'(k) <= span)) begin
        if (!(high_sh[k] < centre_high)) is_high = 1'b0;
        if (!(low_sh[k] > centre_low))   is_low  = 1'b0;
      end
    end
  end

  always_comb begin
    rec_o.clear       = series_start_i;
    rec_o.is_high     = is_high;
    rec_o.is_low      = is_low;
    rec_o.enough      = enough;
    rec_o.centre_high = centre_high;
    rec_o.centre_low  = centre_low;
    rec_o.close       = bar_close_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bars_q <= '0;
    end else if (push_o) begin
      bars_q <= bars_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      for (int k = 0; k < sstd_pkg::WIN_DEPTH; k++) begin
        high_win_q[k] <= high_sh[k];
        low_win_q[k]  <= low_sh[k];
      end
    end
  end

endmodule

/* design/sstd_queue.sv */
// ----------------------------------------------------------------------------
// sstd_queue
// Short queue of classified bars between front and back.
// ----------------------------------------------------------------------------
module sstd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sstd_pkg::rec_t    rec_i,
  input  logic              pop_i,
  output sstd_pkg::rec_t    rec_o,
  output sstd_pkg::q_stat_t stat_o
);

  localparam int PtrW = $clog2(sstd_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(sstd_pkg::QUEUE_DEPTH + 1);

  sstd_pkg::rec_t  slot_q [sstd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = cnt_q == CntW'(sstd_pkg::QUEUE_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign rec_o        = slot_q[rd_q];
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrW'(sstd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = do_pop  ? ((rd_q == PtrW'(sstd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= rec_i;
    end
  end

endmodule

/* design/sstd_back.sv */
// ----------------------------------------------------------------------------
// sstd_back
// Keeps the latest swing pairs, classifies the trend and holds the result.
// ----------------------------------------------------------------------------
module sstd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  sstd_pkg::rec_t                  rec_i,
  output logic                            pop_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [2:0]                      trend_level_o,
  output logic signed [1:0]               trade_signal_o,
  output logic [sstd_pkg::CONF_W-1:0]     confidence_pct_o,
  output logic                            structure_break_o,
  output logic [sstd_pkg::PRICE_BITS-1:0] last_high_level_o,
  output logic [sstd_pkg::PRICE_BITS-1:0] last_low_level_o
);

  logic [sstd_pkg::PRICE_BITS-1:0] hp0_q, hp1_q, lp0_q, lp1_q;
  logic [sstd_pkg::PRICE_BITS-1:0] hp0_d, hp1_d, lp0_d, lp1_d;
  logic [sstd_pkg::PRICE_BITS-1:0] hp0_b, hp1_b, lp0_b, lp1_b;
  logic [1:0]                      hc_q, hc_d, hc_b, lc_q, lc_d, lc_b;
  logic                            valid_q;
  sstd_pkg::trend_e                trend_q, trend_d;
  logic signed [1:0]               sig_q, sig_d;
  logic [sstd_pkg::CONF_W-1:0]     conf_q, conf_d;
  logic                            brk_q, brk_d;
  logic [sstd_pkg::PRICE_BITS-1:0] lh_q, lh_d, ll_q, ll_d;
  logic                            hh, lhi, hl, llo;

  assign pop_o = !q_empty_i && (!valid_q || out_ready_i);

  // swing pair update
  always_comb begin
    hp0_b = rec_i.clear ? '0 : hp0_q;
    hp1_b = rec_i.clear ? '0 : hp1_q;
    lp0_b = rec_i.clear ? '0 : lp0_q;
    lp1_b = rec_i.clear ? '0 : lp1_q;
    hc_b  = rec_i.clear ? '0 : hc_q;
    lc_b  = rec_i.clear ? '0 : lc_q;
    hp0_d = rec_i.is_high ? rec_i.centre_high : hp0_b;
    hp1_d = rec_i.is_high ? hp0_b : hp1_b;
    lp0_d = rec_i.is_low ? rec_i.centre_low : lp0_b;
    lp1_d = rec_i.is_low ? lp0_b : lp1_b;
    hc_d  = (rec_i.is_high && hc_b < sstd_pkg::PAIR_FULL) ? hc_b + 2'd1 : hc_b;
    lc_d  = (rec_i.is_low && lc_b < sstd_pkg::PAIR_FULL) ? lc_b + 2'd1 : lc_b;
  end

  assign hh  = hp0_d > hp1_d;
  assign lhi = hp0_d < hp1_d;
  assign hl  = lp0_d > lp1_d;
  assign llo = lp0_d < lp1_d;

  // trend classification
  always_comb begin
    trend_d = sstd_pkg::TREND_RANGING;
    sig_d   = sstd_pkg::SIG_NONE;
    conf_d  = sstd_pkg::CONF_RANGING;
    brk_d   = 1'b0;
    lh_d    = '0;
    ll_d    = '0;
    if (rec_i.enough && hc_d >= sstd_pkg::PAIR_FULL && lc_d >= sstd_pkg::PAIR_FULL) begin
      lh_d = hp0_d;
      ll_d = lp0_d;
      if (hh && hl) begin
        trend_d = sstd_pkg::TREND_STRONG_BULL;
        sig_d   = sstd_pkg::SIG_LONG;
        conf_d  = sstd_pkg::CONF_STRONG;
      end else if (hh || hl) begin
        trend_d = sstd_pkg::TREND_BULL;
        sig_d   = sstd_pkg::SIG_LONG;
        conf_d  = sstd_pkg::CONF_PLAIN;
      end else if (llo && lhi) begin
        trend_d = sstd_pkg::TREND_STRONG_BEAR;
        sig_d   = sstd_pkg::SIG_SHORT;
        conf_d  = sstd_pkg::CONF_STRONG;
      end else if (llo || lhi) begin
        trend_d = sstd_pkg::TREND_BEAR;
        sig_d   = sstd_pkg::SIG_SHORT;
        conf_d  = sstd_pkg::CONF_PLAIN;
      end
      if (trend_d == sstd_pkg::TREND_BEAR || trend_d == sstd_pkg::TREND_STRONG_BEAR) begin
        brk_d = rec_i.close > hp0_d;
      end else if (trend_d == sstd_pkg::TREND_BULL || trend_d == sstd_pkg::TREND_STRONG_BULL) begin
        brk_d = rec_i.close < lp0_d;
      end
      if (brk_d) begin
        sig_d = -sig_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hc_q    <= '0;
      lc_q    <= '0;
      hp0_q   <= '0;
      hp1_q   <= '0;
      lp0_q   <= '0;
      lp1_q   <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        hc_q    <= hc_d;
        lc_q    <= lc_d;
        hp0_q   <= hp0_d;
        hp1_q   <= hp1_d;
        lp0_q   <= lp0_d;
        lp1_q   <= lp1_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      trend_q <= trend_d;
      sig_q   <= sig_d;
      conf_q  <= conf_d;
      brk_q   <= brk_d;
      lh_q    <= lh_d;
      ll_q    <= ll_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign trend_level_o     = trend_q;
  assign trade_signal_o    = sig_q;
  assign confidence_pct_o  = conf_q;
  assign structure_break_o = brk_q;
  assign last_high_level_o = lh_q;
  assign last_low_level_o  = ll_q;

endmodule

/* design/swing_structure_trend_detector_top.sv */
// ----------------------------------------------------------------------------
// swing_structure_trend_detector_top
// Fractal swing high/low detector with market structure trend classification.
// ----------------------------------------------------------------------------
// One bar is taken per clock cycle, sustained, while the queue is not full, and
// each bar's result passes through the queue slot and the output register. The
// rate holds because the front compares the centre bar against all its window
// neighbors combinationally, and the back updates the swing pairs and classifies
// the trend combinationally ahead of its output register. A two-item queue between
// them and the output register let either side stall without losing items.
// ----------------------------------------------------------------------------
module swing_structure_trend_detector_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sstd_pkg::STR_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            series_start_i,
  input  logic [sstd_pkg::PRICE_BITS-1:0] bar_high_i,
  input  logic [sstd_pkg::PRICE_BITS-1:0] bar_low_i,
  input  logic [sstd_pkg::PRICE_BITS-1:0] bar_close_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      trend_level_o,
  output logic signed [1:0]               trade_signal_o,
  output logic [sstd_pkg::CONF_W-1:0]     confidence_pct_o,
  output logic                            structure_break_o,
  output logic [sstd_pkg::PRICE_BITS-1:0] last_high_level_o,
  output logic [sstd_pkg::PRICE_BITS-1:0] last_low_level_o
);

  logic [sstd_pkg::STR_W-1:0] strength_q, strength_eff;
  logic                       push, pop;
  sstd_pkg::rec_t             rec_in, rec_out;
  sstd_pkg::q_stat_t          q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= sstd_pkg::STRENGTH_RESET;
    end else if (cfg_we_i) begin
      strength_q <= cfg_wdata_i;
    end
  end

  // clamp to the supported range
  always_comb begin
    if (strength_q < sstd_pkg::STRENGTH_MIN) begin
      strength_eff = sstd_pkg::STRENGTH_MIN;
    end else if (strength_q > sstd_pkg::STRENGTH_MAX) begin
      strength_eff = sstd_pkg::STRENGTH_MAX;
    end else begin
      strength_eff = strength_q;
    end
  end

  sstd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .q_full_i       (q_stat.full),
    .strength_i     (strength_eff),
    .series_start_i (series_start_i),
    .bar_high_i     (bar_high_i),
    .bar_low_i      (bar_low_i),
    .bar_close_i    (bar_close_i),
    .in_ready_o     (in_ready_o),
    .push_o         (push),
    .rec_o          (rec_in)
  );

  sstd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec_in),
    .pop_i  (pop),
    .rec_o  (rec_out),
    .stat_o (q_stat)
  );

  sstd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_stat.empty),
    .rec_i             (rec_out),
    .pop_o             (pop),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .trend_level_o     (trend_level_o),
    .trade_signal_o    (trade_signal_o),
    .confidence_pct_o  (confidence_pct_o),
    .structure_break_o (structure_break_o),
    .last_high_level_o (last_high_level_o),
    .last_low_level_o  (last_low_level_o)
  );

  a_wait_queue_drains: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!q_stat.empty && (!out_valid_o || out_ready_i)) |=> out_valid_o
  ) else $error("queued item not moved to output");

  a_break_needs_trend: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && structure_break_o) |-> (trend_level_o != sstd_pkg::TREND_RANGING)
  ) else $error("structure break on ranging trend");

  a_ranging_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && trend_level_o == sstd_pkg::TREND_RANGING) |->
      (confidence_pct_o == sstd_pkg::CONF_RANGING && trade_signal_o == sstd_pkg::SIG_NONE)
  ) else $error("ranging result with signal or wrong confidence");

  a_no_accept_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && !pop) |=> q_stat.full
  ) else $error("queue lost an item");

endmodule

/* test/swing_structure_trend_detector_top_tb.sv */
// ----------------------------------------------------------------------------
// swing_structure_trend_detector_top_tb
// Self-checking bench for the swing structure trend detector.
// ----------------------------------------------------------------------------
// A short table of bars covers price extremes, warm-up and a rising zigzag
// that ends in a structure break. It is followed by random wave-shaped bar
// series under several swing strengths, including the clamped values and
// changes in the middle of a series. A bar-level model in the bench predicts
// every report after the warm-up rows. Both handshakes idle at random, and the
// output side holds off long enough to fill the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swing_structure_trend_detector_top_tb;

  localparam int unsigned RUN_LIMIT      = 200000;
  localparam int unsigned SQUEEZE_CYCLES = 48;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct packed {
    logic                            start;
    logic [sstd_pkg::PRICE_BITS-1:0] hi;
    logic [sstd_pkg::PRICE_BITS-1:0] lo;
    logic [sstd_pkg::PRICE_BITS-1:0] cl;
  } bar_t;

  typedef struct packed {
    sstd_pkg::trend_e                trend;
    logic signed [1:0]               sig;
    logic [sstd_pkg::CONF_W-1:0]     conf;
    logic                            brk;
    logic [sstd_pkg::PRICE_BITS-1:0] hi_lvl;
    logic [sstd_pkg::PRICE_BITS-1:0] lo_lvl;
  } trend_rpt_t;

  typedef struct packed {
    logic                            warmup;
    logic                            start;
    logic [sstd_pkg::PRICE_BITS-1:0] hi;
    logic [sstd_pkg::PRICE_BITS-1:0] lo;
    logic [sstd_pkg::PRICE_BITS-1:0] cl;
  } plan_row_t;

  localparam trend_rpt_t RANGING_RPT = '{sstd_pkg::TREND_RANGING, sstd_pkg::SIG_NONE,
                                         sstd_pkg::CONF_RANGING, 1'b0, '0, '0};

  // warm-up rows are known to report ranging, the zigzag is predicted
  localparam plan_row_t PLAN [24] = '{
    '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
    '{1'b1, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
    '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
    '{1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF},
    '{1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555},
    '{1'b0, 1'b1, 32'd105, 32'd95,  32'd100},
    '{1'b0, 1'b0, 32'd115, 32'd105, 32'd110},
    '{1'b0, 1'b0, 32'd125, 32'd115, 32'd120},
    '{1'b0, 1'b0, 32'd115, 32'd105, 32'd110},
    '{1'b0, 1'b0, 32'd105, 32'd95,  32'd100},
    '{1'b0, 1'b0, 32'd115, 32'd105, 32'd110},
    '{1'b0, 1'b0, 32'd135, 32'd125, 32'd130},
    '{1'b0, 1'b0, 32'd125, 32'd115, 32'd120},
    '{1'b0, 1'b0, 32'd115, 32'd105, 32'd110},
    '{1'b0, 1'b0, 32'd125, 32'd115, 32'd120},
    '{1'b0, 1'b0, 32'd145, 32'd135, 32'd140},
    '{1'b0, 1'b0, 32'd135, 32'd125, 32'd130},
    '{1'b0, 1'b0, 32'd125, 32'd115, 32'd120},
    '{1'b0, 1'b0, 32'd135, 32'd125, 32'd130},
    '{1'b0, 1'b0, 32'd155, 32'd145, 32'd150},
    '{1'b0, 1'b0, 32'd145, 32'd135, 32'd140},
    '{1'b0, 1'b0, 32'd135, 32'd125, 32'd0}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [sstd_pkg::STR_W-1:0]      cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic                            series_start_i;
  logic [sstd_pkg::PRICE_BITS-1:0] bar_high_i;
  logic [sstd_pkg::PRICE_BITS-1:0] bar_low_i;
  logic [sstd_pkg::PRICE_BITS-1:0] bar_close_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [2:0]                      trend_level_o;
  logic signed [1:0]               trade_signal_o;
  logic [sstd_pkg::CONF_W-1:0]     confidence_pct_o;
  logic                            structure_break_o;
  logic [sstd_pkg::PRICE_BITS-1:0] last_high_level_o;
  logic [sstd_pkg::PRICE_BITS-1:0] last_low_level_o;

  // bench copy of the block state
  logic [sstd_pkg::STR_W-1:0]      strength_q;
  logic [sstd_pkg::PRICE_BITS-1:0] high_hist [sstd_pkg::WIN_DEPTH];
  logic [sstd_pkg::PRICE_BITS-1:0] low_hist [sstd_pkg::WIN_DEPTH];
  int unsigned                     bar_count;
  logic [sstd_pkg::PRICE_BITS-1:0] peak_pair [2];
  logic [sstd_pkg::PRICE_BITS-1:0] trough_pair [2];
  int unsigned                     peak_cnt;
  int unsigned                     trough_cnt;

  // price walk for random series
  logic [sstd_pkg::PRICE_BITS-1:0] walk_mid;
  int                              walk_dir;
  int                              walk_left;
  int unsigned                     rise_max;
  int unsigned                     fall_max;

  trend_rpt_t  pending_reports [$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  logic        calm;
  logic        squeeze_due;

  swing_structure_trend_detector_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .series_start_i    (series_start_i),
    .bar_high_i        (bar_high_i),
    .bar_low_i         (bar_low_i),
    .bar_close_i       (bar_close_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .trend_level_o     (trend_level_o),
    .trade_signal_o    (trade_signal_o),
    .confidence_pct_o  (confidence_pct_o),
    .structure_break_o (structure_break_o),
    .last_high_level_o (last_high_level_o),
    .last_low_level_o  (last_low_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned eff_strength();
    if (strength_q < sstd_pkg::STRENGTH_MIN) return 1;
    if (strength_q > sstd_pkg::STRENGTH_MAX) return sstd_pkg::MAX_STRENGTH;
    return int'(strength_q);
  endfunction

  function automatic void clear_history();
    int unsigned i;
    for (i = 0; i < sstd_pkg::WIN_DEPTH; i++) begin
      high_hist[i] = '0;
      low_hist[i]  = '0;
    end
    bar_count      = 0;
    peak_pair[0]   = '0;
    peak_pair[1]   = '0;
    trough_pair[0] = '0;
    trough_pair[1] = '0;
    peak_cnt       = 0;
    trough_cnt     = 0;
  endfunction

  function automatic trend_rpt_t classify_bar(input bar_t b);
    int unsigned                     s;
    int unsigned                     i;
    logic [sstd_pkg::PRICE_BITS-1:0] ch;
    logic [sstd_pkg::PRICE_BITS-1:0] cw;
    logic                            is_h;
    logic                            is_l;
    logic                            hh;
    logic                            lhi;
    logic                            hl;
    logic                            llo;
    trend_rpt_t                      r;
    s = eff_strength();
    r = RANGING_RPT;
    if (b.start) clear_history();
    for (i = sstd_pkg::WIN_DEPTH - 1; i > 0; i--) begin
      high_hist[i] = high_hist[i-1];
      low_hist[i]  = low_hist[i-1];
    end
    high_hist[0] = b.hi;
    low_hist[0]  = b.lo;
    if (bar_count < sstd_pkg::BARS_MAX) bar_count++;
    if (bar_count >= 2 * s + 1) begin
      ch   = high_hist[s];
      cw   = low_hist[s];
      is_h = 1'b1;
      is_l = 1'b1;
      for (i = 1; i <= s; i++) begin
        if (ch <= high_hist[s-i] || ch <= high_hist[s+i]) is_h = 1'b0;
        if (cw >= low_hist[s-i] || cw >= low_hist[s+i]) is_l = 1'b0;
      end
      if (is_h) begin
        peak_pair[1] = peak_pair[0];
        peak_pair[0] = ch;
        if (peak_cnt < sstd_pkg::PAIR_FULL) peak_cnt++;
      end
      if (is_l) begin
        trough_pair[1] = trough_pair[0];
        trough_pair[0] = cw;
        if (trough_cnt < sstd_pkg::PAIR_FULL) trough_cnt++;
      end
    end
    if (bar_count >= 4 * s && peak_cnt >= sstd_pkg::PAIR_FULL &&
        trough_cnt >= sstd_pkg::PAIR_FULL) begin
      hh  = peak_pair[0] > peak_pair[1];
      lhi = peak_pair[0] < peak_pair[1];
      hl  = trough_pair[0] > trough_pair[1];
      llo = trough_pair[0] < trough_pair[1];
      r.hi_lvl = peak_pair[0];
      r.lo_lvl = trough_pair[0];
      if (hh && hl) begin
        r.trend = sstd_pkg::TREND_STRONG_BULL;
        r.sig   = sstd_pkg::SIG_LONG;
        r.conf  = sstd_pkg::CONF_STRONG;
      end else if (hh || hl) begin
        r.trend = sstd_pkg::TREND_BULL;
        r.sig   = sstd_pkg::SIG_LONG;
        r.conf  = sstd_pkg::CONF_PLAIN;
      end else if (llo && lhi) begin
        r.trend = sstd_pkg::TREND_STRONG_BEAR;
        r.sig   = sstd_pkg::SIG_SHORT;
        r.conf  = sstd_pkg::CONF_STRONG;
      end else if (llo || lhi) begin
        r.trend = sstd_pkg::TREND_BEAR;
        r.sig   = sstd_pkg::SIG_SHORT;
        r.conf  = sstd_pkg::CONF_PLAIN;
      end
      if (r.trend == sstd_pkg::TREND_BEAR || r.trend == sstd_pkg::TREND_STRONG_BEAR) begin
        r.brk = b.cl > r.hi_lvl;
      end else if (r.trend == sstd_pkg::TREND_BULL ||
                   r.trend == sstd_pkg::TREND_STRONG_BULL) begin
        r.brk = b.cl < r.lo_lvl;
      end
      if (r.brk) r.sig = (r.sig == sstd_pkg::SIG_LONG) ? sstd_pkg::SIG_SHORT
                                                       : sstd_pkg::SIG_LONG;
    end
    return r;
  endfunction

  function automatic void start_walk();
    walk_mid  = $urandom_range(32'h1000_0000, 32'hE000_0000);
    walk_dir  = 1;
    walk_left = 0;
    rise_max  = 20 * $urandom_range(1, 3);
    fall_max  = 20 * $urandom_range(1, 3);
  endfunction

  function automatic bar_t next_walk_bar(input logic start);
    bar_t        b;
    int unsigned s;
    int unsigned step;
    s = eff_strength();
    if (walk_left <= 0) begin
      walk_dir  = -walk_dir;
      walk_left = $urandom_range((s > 1) ? s - 1 : 1, 2 * s + 2);
    end
    walk_left--;
    if (walk_dir > 0) begin
      step     = $urandom_range(0, rise_max);
      walk_mid = walk_mid + step;
    end else begin
      step     = $urandom_range(0, fall_max);
      walk_mid = walk_mid - step;
    end
    b.start = start;
    b.hi    = walk_mid + $urandom_range(0, 6);
    b.lo    = walk_mid - $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0:       b.cl = b.hi + $urandom_range(0, 800);
      1:       b.cl = b.lo - $urandom_range(0, 800);
      2:       b.cl = $urandom_range(b.lo, b.hi);
      default: b.cl = walk_mid;
    endcase
    // rare noise bar, keeps every price bit moving
    if ($urandom_range(0, 10 * s) == 0) begin
      b.hi = $urandom;
      b.lo = $urandom;
      b.cl = $urandom;
    end
    return b;
  endfunction

  task automatic push_bar(input bar_t b, input logic warmup);
    int unsigned gap;
    trend_rpt_t  want;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    series_start_i <= b.start;
    bar_high_i     <= b.hi;
    bar_low_i      <= b.lo;
    bar_close_i    <= b.cl;
    do @(posedge clk_i); while (!in_ready_o);
    want = classify_bar(b);
    pending_reports.insert(pending_reports.size(), warmup ? RANGING_RPT : want);
    @(negedge clk_i);
  endtask

  task automatic write_strength(input logic [sstd_pkg::STR_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    strength_q = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [sstd_pkg::STR_W-1:0] strength,
                           input int unsigned items,
                           input logic fresh, input logic squeeze);
    int unsigned k;
    int unsigned s;
    int unsigned series_left;
    bar_t        b;
    write_strength(strength);
    if (squeeze) squeeze_due = 1'b1;
    s = eff_strength();
    series_left = fresh ? 0 : $urandom_range(12 * s + 20, 20 * s + 40);
    for (k = 0; k < items; k++) begin
      if (series_left == 0) begin
        start_walk();
        series_left = $urandom_range(12 * s + 20, 20 * s + 40);
        b = next_walk_bar(1'b1);
      end else begin
        b = next_walk_bar(1'b0);
      end
      series_left--;
      push_bar(b, 1'b0);
    end
  endtask

  // output side, random stalls plus one long hold-off on request
  initial begin
    int unsigned hold;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_due) begin
        squeeze_due = 1'b0;
        out_ready_i <= 1'b0;
        repeat (SQUEEZE_CYCLES - 1) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        hold = $urandom_range(1, 4);
        repeat (hold - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    trend_rpt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
          $display("unexpected report: trend %0d sig %0d conf %0d brk %0b hi %0h lo %0h",
                   trend_level_o, trade_signal_o, confidence_pct_o, structure_break_o,
                   last_high_level_o, last_low_level_o);
        end
      end else begin
        want = pending_reports.pop_front();
        if (trend_level_o !== want.trend || trade_signal_o !== want.sig ||
            confidence_pct_o !== want.conf || structure_break_o !== want.brk ||
            last_high_level_o !== want.hi_lvl || last_low_level_o !== want.lo_lvl) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX) begin
            $display("report mismatch at cycle %0d", cycle_cnt);
            $display("  want: trend %0d sig %0d conf %0d brk %0b hi %0h lo %0h",
                     want.trend, want.sig, want.conf, want.brk, want.hi_lvl, want.lo_lvl);
            $display("  got:  trend %0d sig %0d conf %0d brk %0b hi %0h lo %0h",
                     trend_level_o, trade_signal_o, confidence_pct_o, structure_break_o,
                     last_high_level_o, last_low_level_o);
          end
        end
      end
    end
  end

  initial begin
    int unsigned row;
    bar_t        b;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = sstd_pkg::STRENGTH_RESET;
    in_valid_i     = 1'b0;
    series_start_i = 1'b0;
    bar_high_i     = '0;
    bar_low_i      = '0;
    bar_close_i    = '0;
    calm           = 1'b0;
    squeeze_due    = 1'b0;
    fail_cnt       = 0;
    strength_q     = sstd_pkg::STRENGTH_RESET;
    clear_history();
    start_walk();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (row = 0; row < $size(PLAN); row++) begin
      b = '{PLAN[row].start, PLAN[row].hi, PLAN[row].lo, PLAN[row].cl};
      push_bar(b, PLAN[row].warmup);
    end

    run_phase(5'd2, 130, 1'b1, 1'b1);
    run_phase(5'd1, 100, 1'b1, 1'b0);
    run_phase(5'd0, 60, 1'b0, 1'b0);
    run_phase(5'd16, 160, 1'b1, 1'b1);
    run_phase(5'd31, 80, 1'b0, 1'b0);
    run_phase(5'($urandom_range(3, 15)), 80, 1'b0, 1'b0);
    calm = 1'b1;
    run_phase(5'd3, 80, 1'b1, 1'b0);

    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
